[design/lsh_pkg.sv]
`default_nettype none

package lsh_pkg;

  localparam int IDX_W = 14;
  localparam int ROW_W = 12;
  localparam int CFG_W = 13;
  localparam int CH_W  = 3;

  // result queue depth; must hold two results of one item plus slack
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  localparam int CENTER_GAIN = 5;

  // register map (index = paddr[3:2])
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RST    = 13'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RST   = 13'd512;
  localparam logic [CH_W-1:0]  CHANNELS_RST = 3'd1;

  typedef struct packed {
    logic [7:0] sample_value;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       sharp_value;
    logic [ROW_W-1:0] out_row;
    logic [IDX_W-1:0] out_sample_index;
    logic             last_of_run;
  } out_word_t;

endpackage

`default_nettype wire

[design/laplacian_sharpen_3x3.sv]
`default_nettype none

// 3x3 Laplacian sharpening filter for raster-order 8-bit samples with
// channels interleaved. Each center gives 5*center minus its left, right,
// up and down neighbors of the same channel, clamped to 0..255; samples in
// the first or last row or pixel column give zero. The result for row r-1
// leaves when the sample of row r at the same index arrives, so row 0 gives
// no result, and every sample of the last row gives a second word: the zero
// bottom-row sample, flagged by last_of_run. The block accepts one input word
// per clock while in_stall is low; a word's results pass through the
// synchronous line-buffer read and then the result queue. Sustained rate is
// one word per clock unless out_stall is high, bounded in the last row, where
// each input makes two results and the single output port drains one per
// clock. The line buffers are two LINE_SAMPLES x 8 memories (the middle line
// is read at two addresses, center and right neighbor); their contents are
// undefined until the first rows of a frame have been written. Width times
// channels is cut to LINE_SAMPLES. Program image_width (0x0), image_height
// (0x4) and channel_count (0x8) only while the block is idle.
module laplacian_sharpen_3x3 #(
  parameter int LINE_SAMPLES = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lsh_pkg::in_word_t   in_data,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output lsh_pkg::out_word_t       out_data,

  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int AW = (LINE_SAMPLES > 1) ? $clog2(LINE_SAMPLES) : 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [lsh_pkg::CFG_W-1:0] width_r;
  logic [lsh_pkg::CFG_W-1:0] height_r;
  logic [lsh_pkg::CH_W-1:0]  chan_r;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lsh_pkg::WIDTH_RST;
      height_r <= lsh_pkg::HEIGHT_RST;
      chan_r   <= lsh_pkg::CHANNELS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lsh_pkg::REG_WIDTH:    width_r  <= pwdata[lsh_pkg::CFG_W-1:0];
        lsh_pkg::REG_HEIGHT:   height_r <= pwdata[lsh_pkg::CFG_W-1:0];
        lsh_pkg::REG_CHANNELS: chan_r   <= pwdata[lsh_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lsh_pkg::REG_WIDTH:    prdata = {19'd0, width_r};
      lsh_pkg::REG_HEIGHT:   prdata = {19'd0, height_r};
      lsh_pkg::REG_CHANNELS: prdata = {29'd0, chan_r};
      default:               prdata = 32'd0;
    endcase
  end

  // Effective geometry: zero acts as one, channels capped, height capped at
  // 4096, row length capped at the line buffer size. Kept combinational so
  // a word right after a register write sees the new value.
  logic [lsh_pkg::CH_W-1:0]  c_eff;
  logic [lsh_pkg::CFG_W-1:0] w_eff;
  logic [lsh_pkg::CFG_W-1:0] h_eff;
  logic [15:0]               row_prod;
  logic [15:0]               n_eff;

  always_comb begin
    if (chan_r == '0) begin
      c_eff = lsh_pkg::CH_W'(1);
    end else if (chan_r > lsh_pkg::CH_W'(MAX_CHANNELS)) begin
      c_eff = lsh_pkg::CH_W'(MAX_CHANNELS);
    end else begin
      c_eff = chan_r;
    end
    w_eff = (width_r == '0) ? lsh_pkg::CFG_W'(1) : width_r;
    if (height_r == '0) begin
      h_eff = lsh_pkg::CFG_W'(1);
    end else if (height_r > lsh_pkg::CFG_W'(4096)) begin
      h_eff = lsh_pkg::CFG_W'(4096);
    end else begin
      h_eff = height_r;
    end
    row_prod = 16'(w_eff) * 16'(c_eff);
    n_eff    = (row_prod > 16'(LINE_SAMPLES)) ? 16'(LINE_SAMPLES) : row_prod;
  end

  // ---------------------------------------------------------------------
  // Accept stage: position tracking and read address generation
  // ---------------------------------------------------------------------
  logic [lsh_pkg::IDX_W-1:0] s_pos_r, s_pos_nxt;
  logic [lsh_pkg::ROW_W-1:0] r_pos_r, r_pos_nxt;
  logic                      in_acc;

  logic [lsh_pkg::IDX_W-1:0] s_sel, s_cur;
  logic [lsh_pkg::ROW_W-1:0] r_sel, r_cur;
  logic [15:0]               s_ext;
  logic [15:0]               c_ext;
  logic [15:0]               s_inc;
  logic [lsh_pkg::CFG_W-1:0] r_inc;
  logic                      cur_has_up;
  logic                      cur_last_row;
  logic                      cur_border;
  logic [AW-1:0]             addr_c;
  logic [AW-1:0]             addr_right;

  assign in_acc = in_valid & ~in_stall;

  always_comb begin
    s_sel = in_data.frame_start ? '0 : s_pos_r;
    r_sel = in_data.frame_start ? '0 : r_pos_r;
    s_cur = (16'(s_sel) >= n_eff) ? '0 : s_sel;
    r_cur = (lsh_pkg::CFG_W'(r_sel) >= h_eff) ? '0 : r_sel;

    s_ext = 16'(s_cur);
    c_ext = 16'(c_eff);
    cur_has_up   = (r_cur != '0);
    cur_last_row = (lsh_pkg::CFG_W'(r_cur) + lsh_pkg::CFG_W'(1) == h_eff);
    cur_border   = (r_cur == lsh_pkg::ROW_W'(1)) || (s_ext < c_ext) ||
                   (s_ext + c_ext >= n_eff);

    addr_c = AW'(s_cur);
    // right neighbor only matters off the border, where it stays in range
    addr_right = cur_border ? AW'(s_cur) : AW'(s_ext + c_ext);

    // advance the raster position
    s_inc = s_ext + 16'd1;
    r_inc = lsh_pkg::CFG_W'(r_cur) + lsh_pkg::CFG_W'(1);
    if (s_inc >= n_eff) begin
      s_pos_nxt = '0;
      r_pos_nxt = (r_inc >= h_eff) ? '0 : r_inc[lsh_pkg::ROW_W-1:0];
    end else begin
      s_pos_nxt = s_inc[lsh_pkg::IDX_W-1:0];
      r_pos_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_pos_r <= '0;
      r_pos_r <= '0;
    end else if (in_acc) begin
      s_pos_r <= s_pos_nxt;
      r_pos_r <= r_pos_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Line buffers
  // ---------------------------------------------------------------------
  logic [7:0] mid_mem [LINE_SAMPLES];
  logic [7:0] up_mem  [LINE_SAMPLES];
  logic [7:0] rd_mid_r;
  logic [7:0] rd_right_r;
  logic [7:0] rd_up_r;

  logic                      s1_v_r;
  logic                      s1_go;
  logic [lsh_pkg::IDX_W-1:0] s1_s_r;
  logic [lsh_pkg::ROW_W-1:0] s1_row_r;
  logic [lsh_pkg::CH_W-1:0]  s1_c_r;
  logic                      s1_up_r;
  logic                      s1_last_r;
  logic                      s1_border_r;
  logic [7:0]                s1_sample_r;
  logic                      s1_fwd_r;
  logic [7:0]                s1_fwd_data_r;
  logic [AW-1:0]             s1_addr;

  assign s1_addr = AW'(s1_s_r);

  // Middle line: read center and right, replace center with the new sample
  // (read returns the old value). Upper line takes the old middle sample
  // once it is back from the read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_mid_r         <= mid_mem[addr_c];
      rd_right_r       <= mid_mem[addr_right];
      rd_up_r          <= up_mem[addr_c];
      mid_mem[addr_c]  <= in_data.sample_value;
    end
    if (s1_go) begin
      up_mem[s1_addr] <= rd_mid_r;
    end
  end

  // ---------------------------------------------------------------------
  // Compute stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_s_r      <= s_cur;
      s1_row_r    <= r_cur;
      s1_c_r      <= c_eff;
      s1_up_r     <= cur_has_up;
      s1_last_r   <= cur_last_row;
      s1_border_r <= cur_border;
      s1_sample_r <= in_data.sample_value;
      // the upper-line write of the word leaving now lands at this same edge
      s1_fwd_r      <= s1_go && (s1_addr == addr_c);
      s1_fwd_data_r <= rd_mid_r;
    end
  end

  // Window of recent middle-line centers, newest at index 0.
  logic [7:0] win_r [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        win_r[k] <= '0;
      end
    end else if (s1_go) begin
      win_r[0] <= rd_mid_r;
      for (int k = 1; k < MAX_CHANNELS; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  logic [7:0]  left_px;
  logic [7:0]  up_px;
  logic [11:0] acc;
  logic [7:0]  sharp;

  always_comb begin
    left_px = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (s1_c_r == lsh_pkg::CH_W'(k + 1)) begin
        left_px = win_r[k];
      end
    end
    up_px = s1_fwd_r ? s1_fwd_data_r : rd_up_r;
    // two's complement in 12 bits: 5*255 and -4*255 both fit
    acc = 12'(lsh_pkg::CENTER_GAIN) * 12'(rd_mid_r) - 12'(left_px) -
          12'(rd_right_r) - 12'(up_px) - 12'(s1_sample_r);
    if (acc[11]) begin
      sharp = 8'd0;
    end else if (acc[10:8] != 3'd0) begin
      sharp = 8'd255;
    end else begin
      sharp = acc[7:0];
    end
  end

  lsh_pkg::out_word_t res_a;
  lsh_pkg::out_word_t res_b;
  logic [1:0]         s1_nres;

  always_comb begin
    res_a.sharp_value      = s1_border_r ? 8'd0 : sharp;
    res_a.out_row          = s1_row_r - lsh_pkg::ROW_W'(1);
    res_a.out_sample_index = s1_s_r;
    res_a.last_of_run      = ~s1_last_r;

    res_b.sharp_value      = 8'd0;
    res_b.out_row          = s1_row_r;
    res_b.out_sample_index = s1_s_r;
    res_b.last_of_run      = 1'b1;

    s1_nres = 2'(s1_up_r) + 2'(s1_last_r);
  end

  // ---------------------------------------------------------------------
  // Result queue: takes up to two words per cycle; unless stalled, drains one
  // ---------------------------------------------------------------------
  lsh_pkg::out_word_t          oq_r [lsh_pkg::OQ_DEPTH];
  logic [lsh_pkg::OQ_PTR_W-1:0] oq_wp_r;
  logic [lsh_pkg::OQ_PTR_W-1:0] oq_rp_r;
  logic [lsh_pkg::OQ_CNT_W-1:0] oq_cnt_r;
  logic [lsh_pkg::OQ_CNT_W-1:0] oq_free;
  logic                         oq_pop;
  logic [lsh_pkg::OQ_PTR_W-1:0] oq_wp_b;

  assign oq_free  = lsh_pkg::OQ_CNT_W'(lsh_pkg::OQ_DEPTH) - oq_cnt_r;
  assign s1_go    = s1_v_r && (oq_free >= lsh_pkg::OQ_CNT_W'(s1_nres));
  assign in_stall = s1_v_r && !s1_go;
  assign oq_pop   = out_valid && !out_stall;
  assign oq_wp_b  = s1_up_r ? oq_wp_r + lsh_pkg::OQ_PTR_W'(1) : oq_wp_r;

  assign out_valid = (oq_cnt_r != '0);
  assign out_data  = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (s1_go) begin
      if (s1_up_r) begin
        oq_r[oq_wp_r] <= res_a;
      end
      if (s1_last_r) begin
        oq_r[oq_wp_b] <= res_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (s1_go) begin
        oq_wp_r <= oq_wp_r + lsh_pkg::OQ_PTR_W'(s1_nres);
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + lsh_pkg::OQ_PTR_W'(1);
      end
      oq_cnt_r <= oq_cnt_r +
                  (s1_go ? lsh_pkg::OQ_CNT_W'(s1_nres) : lsh_pkg::OQ_CNT_W'(0)) -
                  lsh_pkg::OQ_CNT_W'(oq_pop);
    end
  end

endmodule

`default_nettype wire

[tb/laplacian_checker.sv]
`timescale 1ns / 100ps

module laplacian_checker #(
  parameter int LINE_SAMPLES = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  lsh_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  lsh_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending_words
);
  import lsh_pkg::*;

  localparam int MAX_ROWS  = 1 << ROW_W;
  localparam int PRINT_CAP = 100;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [CH_W-1:0]  chan_reg;

  logic [7:0] upper_row  [LINE_SAMPLES];
  logic [7:0] middle_row [LINE_SAMPLES];
  // recent middle-row reads, newest at 0
  logic [7:0] row_window [MAX_CHANNELS+1];
  int unsigned row_pos;
  int unsigned idx_pos;

  out_word_t sharp_words_due [$];
  int mismatch_count = 0;

  assign fail_count = mismatch_count;

  // print a bounded number of lines, count every one
  task automatic report_mismatch(input string line);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: %s", $time, line);
    mismatch_count++;
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (sharp_words_due.size() == 0) begin
      report_mismatch($sformatf("result word with none due: row %0d index %0d value %0d",
                                got.out_row, got.out_sample_index, got.sharp_value));
      return;
    end
    want = sharp_words_due.pop_front();
    if (got.sharp_value !== want.sharp_value)
      report_mismatch($sformatf("sharp_value at row %0d index %0d: got %0d, expected %0d",
                                want.out_row, want.out_sample_index,
                                got.sharp_value, want.sharp_value));
    if (got.out_row !== want.out_row)
      report_mismatch($sformatf("out_row at index %0d: got %0d, expected %0d",
                                want.out_sample_index, got.out_row, want.out_row));
    if (got.out_sample_index !== want.out_sample_index)
      report_mismatch($sformatf("out_sample_index at row %0d: got %0d, expected %0d",
                                want.out_row, got.out_sample_index, want.out_sample_index));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch($sformatf("last_of_run at row %0d index %0d: got %0d, expected %0d",
                                want.out_row, want.out_sample_index,
                                got.last_of_run, want.last_of_run));
  endtask

  // advance the filter by one input word and queue the words it gives
  task automatic sharpen_predict(input in_word_t word);
    int unsigned chans;
    int unsigned row_len;
    int unsigned rows;
    int unsigned r;
    int unsigned s;
    int          acc;
    int          i;
    out_word_t   res;
    chans = (chan_reg == 0) ? 1 : chan_reg;
    if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;
    row_len = ((width_reg == 0) ? 1 : width_reg) * chans;
    if (row_len > LINE_SAMPLES) row_len = LINE_SAMPLES;
    rows = (height_reg == 0) ? 1 : height_reg;
    if (rows > MAX_ROWS) rows = MAX_ROWS;

    if (word.frame_start) begin
      row_pos = 0;
      idx_pos = 0;
    end
    if (row_pos >= rows) row_pos = 0;
    if (idx_pos >= row_len) idx_pos = 0;
    r = row_pos;
    s = idx_pos;

    for (i = MAX_CHANNELS; i > 0; i--) row_window[i] = row_window[i-1];
    row_window[0] = middle_row[s];

    if (r >= 1) begin
      acc = 0;
      // border: top row of the image, first or last pixel column
      if (r > 1 && s >= chans && s + chans < row_len) begin
        acc = CENTER_GAIN * int'(row_window[0]) - int'(row_window[chans])
              - int'(middle_row[s + chans]) - int'(upper_row[s])
              - int'(word.sample_value);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
      end
      res.sharp_value      = acc[7:0];
      res.out_row          = ROW_W'(r - 1);
      res.out_sample_index = IDX_W'(s);
      res.last_of_run      = (r + 1 != rows);
      sharp_words_due.push_back(res);
    end
    // last row: the bottom-row sample itself is border, always zero
    if (r + 1 == rows) begin
      res.sharp_value      = '0;
      res.out_row          = ROW_W'(r);
      res.out_sample_index = IDX_W'(s);
      res.last_of_run      = 1'b1;
      sharp_words_due.push_back(res);
    end

    upper_row[s]  = middle_row[s];
    middle_row[s] = word.sample_value;

    s++;
    if (s >= row_len) begin
      s = 0;
      r++;
      if (r >= rows) r = 0;
    end
    idx_pos = s;
    row_pos = r;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      chan_reg   = CHANNELS_RST;
      foreach (upper_row[k]) begin
        upper_row[k]  = '0;
        middle_row[k] = '0;
      end
      foreach (row_window[k]) row_window[k] = '0;
      row_pos = 0;
      idx_pos = 0;
      sharp_words_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WIDTH:    width_reg  = pwdata[CFG_W-1:0];
          REG_HEIGHT:   height_reg = pwdata[CFG_W-1:0];
          REG_CHANNELS: chan_reg   = pwdata[CH_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting: a word cannot leave at its own acceptance edge
      if (out_valid && !out_stall) check_word(out_data);
      if (in_valid && !in_stall) sharpen_predict(in_data);
    end
    pending_words <= sharp_words_due.size();
  end

endmodule

[tb/tb_laplacian_sharpen_3x3.sv]
`timescale 1ns / 100ps

module tb_laplacian_sharpen_3x3;
  import lsh_pkg::*;

  localparam int LINE_SAMPLES     = 4096;
  localparam int MAX_CHANNELS     = 4;
  // random stimulus budget, in input words; the directed frames add about 190
  localparam int RANDOM_ITEMS     = 1560;
  // give the pipeline a generous margin before config
  localparam int SETTLE_CYCLES    = 10;
  localparam int LONG_HOLD_CYCLES = 400;
  // cycles in which no word moves on either channel before the run is declared hung
  localparam int IDLE_LIMIT       = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_words;

  // sender offers back to back when set
  bit sender_steady;
  // one-shot request for a long receiver hold-off, cleared by the stall process
  bit long_hold_req;

  laplacian_sharpen_3x3 #(
    .LINE_SAMPLES(LINE_SAMPLES),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // watches both channels and the register port, predicts and compares
  laplacian_checker #(
    .LINE_SAMPLES(LINE_SAMPLES),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) sharp_check (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data,
    .psel,
    .penable,
    .pwrite,
    .pready,
    .paddr,
    .pwdata,
    .fail_count,
    .pending_words
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  // Mix of noise, hard extremes (to drive the clamps) and a smooth patch
  // around a base level (to get unclamped mid-range results).
  function automatic logic [7:0] pick_sample(input logic [7:0] base);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom);
    if (r < 6) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return base + 8'($urandom_range(0, 15)) - 8'd8;
  endfunction

  // Offer one word after an optional gap and hold it until taken. Valid is
  // raised regardless of stall; the payload stays put while stalled.
  task automatic send_word(input in_word_t word);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted word has come out. A word in
  // row 0 gives nothing, so also let the pipeline run dry afterwards.
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access; back-to-back writes keep psel high.
  // Junk in the upper pwdata bits must be ignored by the register.
  task automatic apb_write(input logic [1:0] reg_idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {19'($urandom), 13'(value)};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int w, input int h, input int c);
    settle_idle();
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_CHANNELS, c);
    apb_release();
  endtask

  // One setting, one stream. The first word always starts a frame so that no
  // line-buffer entry is read before this frame has written it. Short streams
  // get an occasional restart in the middle of a frame; long ones run clean so
  // they reach their last rows.
  task automatic run_phase(input int w, input int h, input int c, input int count,
                           input bit pause_midway, input bit hold_receiver);
    logic [7:0] base;
    in_word_t   word;
    int         k;
    set_config(w, h, c);
    base = 8'($urandom);
    sender_steady = hold_receiver || ($urandom_range(0, 3) == 0);
    // keep offering while the receiver sits: the block must fill and stall
    if (hold_receiver) long_hold_req = 1'b1;
    for (k = 0; k < count; k++) begin
      word.sample_value = pick_sample(base);
      word.frame_start  = (k == 0) || (count < 1000 && $urandom_range(0, 199) == 0);
      send_word(word);
      if ((pause_midway && k == count / 2) || $urandom_range(0, 299) == 0)
        settle_idle();
    end
  endtask

  // Receiver: alternate runs of stall and no stall, with the odd long quiet
  // stretch; a requested long hold overrides everything.
  initial begin : receiver_stall
    int run_left;
    int hold_left;
    int r;
    run_left  = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(0, 4);
        end else if (r < 80) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(0, 2);
        end else if (r < 95) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(20, 120);
        end else begin
          out_stall <= 1'b1;
          run_left = $urandom_range(8, 30);
        end
      end
    end
  end

  // Hang detector: count cycles in which neither channel moves a word.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    in_word_t word;
    int       k;
    int       random_items;
    int       phase_no;
    int       w;
    int       h;
    int       c;
    int       ce;
    int       n;
    int       count;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    sender_steady = 1'b0;
    long_hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Two 3x3 frames, one pixel each of interior. First: a lone bright center
    // on black, clamps high. Second: a dark center in white, clamps low.
    set_config(3, 3, 1);
    for (k = 0; k < 18; k++) begin
      word.frame_start = (k % 9 == 0);
      if (k < 9) word.sample_value = (k == 4) ? 8'hFF : 8'h00;
      else       word.sample_value = (k == 13) ? 8'h00 : 8'hFF;
      send_word(word);
    end

    // Width zero acts as one pixel: every sample sits on the border.
    run_phase(0, 3, 2, 12, 1'b0, 1'b0);
    // Height zero acts as one row, channel count zero as one: every word is
    // in the last row and gives only the zero bottom sample.
    run_phase(5, 0, 0, 12, 1'b0, 1'b0);
    // Height above the row range clamps to 4096; one sample per row steps
    // the row counter once per word.
    run_phase(0, 8191, 0, 40, 1'b0, 1'b0);
    // Height at its top, channel count above the maximum clamps to four.
    run_phase(3, 4096, 5, 64, 1'b0, 1'b0);
    // Width 4096 with four channels in a one-row frame: the row is cut
    // to the line length and every word gives its zero bottom sample.
    run_phase(4096, 1, 4, 40, 1'b0, 1'b0);

    // Random settings, mostly small images run through whole frames. The
    // first phase pauses for a full drain halfway, the second holds the
    // receiver off for a long stretch.
    random_items = 0;
    phase_no     = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        w = $urandom_range(11, 48);
        h = 3;
      end else begin
        w = $urandom_range(3, 10);
        h = $urandom_range(3, 6);
      end
      if ($urandom_range(0, 9) == 0)
        c = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(5, 7);
      else
        c = $urandom_range(1, MAX_CHANNELS);
      ce = (c == 0) ? 1 : ((c > MAX_CHANNELS) ? MAX_CHANNELS : c);
      n  = w * ce;
      count = n * h * $urandom_range(1, 2) + $urandom_range(0, n);
      // stay within the budget
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      if (phase_no == 1 && count < 60) count = 60;
      run_phase(w, h, c, count, phase_no == 0, phase_no == 1);
      random_items += count;
      phase_no++;
    end

    // Drain everything, then watch a little longer for strays.
    settle_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/lsh_pkg.sv
design/laplacian_sharpen_3x3.sv
tb/laplacian_checker.sv
tb/tb_laplacian_sharpen_3x3.sv
